// ----- hdl/pcb_pkg.sv -----
// ----------------------------------------------------------------------------
// pcb_pkg
// shared types, codes and sizes of the particle cell binning unit
// ----------------------------------------------------------------------------
package pcb_pkg;

	localparam int NUM_CELLS_DEF  = 4096;
	localparam int COUNT_BITS_DEF = 16;

	localparam int POS_W   = 32;
	localparam int INV_W   = 32;
	localparam int ORG_W   = 16;
	localparam int LEN_W   = 12;
	localparam int IDX_W   = 12;
	localparam int OUTC_W  = 16;
	localparam int KEY_W   = 64;
	localparam int PROD_W  = 64;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int SDATA_W = 112;
	localparam int SUSER_W = 3;
	localparam int MDATA_W = 32;
	localparam int MUSER_W = 2;

	// commands
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_BIN   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// geometry modes
	localparam logic [1:0] MODE_1D  = 2'd0;
	localparam logic [1:0] MODE_2D  = 2'd1;
	localparam logic [1:0] MODE_3D  = 2'd2;
	localparam logic [1:0] MODE_CYL = 2'd3;

	// register indexes
	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_INV0    = 3'd1;
	localparam logic [2:0] REG_INV1    = 3'd2;
	localparam logic [2:0] REG_INV2    = 3'd3;
	localparam logic [2:0] REG_ORG0    = 3'd4;
	localparam logic [2:0] REG_ORG1    = 3'd5;
	localparam logic [2:0] REG_ORG2    = 3'd6;
	localparam logic [2:0] REG_LENGTHS = 3'd7;

	localparam logic [1:0] AXIS_0 = 2'd0;
	localparam logic [1:0] AXIS_1 = 2'd1;
	localparam logic [1:0] AXIS_2 = 2'd2;

	typedef struct packed {
		logic [1:0]                  mode;
		logic [2:0][INV_W-1:0]       inv_dx;
		logic [2:0][ORG_W-1:0]       origin;
		logic [LEN_W-1:0]            len1;
		logic [LEN_W-1:0]            len2;
	} cfg_t;

	typedef enum logic [2:0] {
		MUL_X, MUL_Y, MUL_Z, MUL_SQY, MUL_SQZ, MUL_RAD
	} mul_sel_t;

	typedef enum logic [1:0] {
		FOLD_NONE, FOLD_LOAD, FOLD_L1, FOLD_L2
	} fold_op_t;

	typedef enum logic [2:0] {
		FL_NONE, FL_ZERO, FL_READ, FL_BIN_OOR, FL_BIN_OK
	} flag_op_t;

	typedef struct packed {
		logic       load_item;
		logic       mul_en;
		mul_sel_t   mul_sel;
		fold_op_t   fold_op;
		logic [1:0] axis;
		logic       radial;
		logic       sum_load;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       clr_step;
		logic       rd_idx;
		logic       rd_key;
		logic       inc_write;
		flag_op_t   flag_op;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       excluded;
		logic [1:0] mode;
		logic       key_oor;
		logic       sqrt_done;
		logic       clr_done;
		logic       out_free;
	} dp_sts_t;

endpackage

// ----- hdl/particle_cell_binning_unit.sv -----
// ----------------------------------------------------------------------------
// particle_cell_binning_unit
// histogram of particles over grid cells with clear, bin and read commands
// ----------------------------------------------------------------------------
// One item is handled at a time by a sequencer over a single shared 32x32
// multiplier. Bin works in 1D, 2D, 3D and cylindrical mode, the last with a
// bit-serial square root, and then hands the result to the output register;
// a key outside the store skips the store update. A clear sweeps the store
// at one entry a cycle. After reset the same sweep runs before the first
// item is taken; register writes are taken at any time. A finished result
// waits in the output register while the next item is already accepted.
module particle_cell_binning_unit #(
	parameter int NUM_CELLS  = pcb_pkg::NUM_CELLS_DEF,
	parameter int COUNT_BITS = pcb_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pcb_pkg::PADDR_W-1:0]   paddr,
	input  logic [pcb_pkg::PDATA_W-1:0]   pwdata,
	output logic [pcb_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pcb_pkg::SDATA_W-1:0]   s_tdata,  // pos_x, pos_y, pos_z, cell_index
	input  logic [pcb_pkg::SUSER_W-1:0]   s_tuser,  // command, excluded
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pcb_pkg::MDATA_W-1:0]   m_tdata,  // cell_key, bin_count
	output logic [pcb_pkg::MUSER_W-1:0]   m_tuser   // binned, out_of_range
);
	import pcb_pkg::*;

	cfg_t    cfg;
	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	pcb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	pcb_datapath #(
		.NUM_CELLS  (NUM_CELLS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (dp_cmd),
		.sts      (dp_sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- hdl/pcb_regs.sv -----
// ----------------------------------------------------------------------------
// pcb_regs
// configuration registers behind the register bus port
// ----------------------------------------------------------------------------
module pcb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pcb_pkg::PADDR_W-1:0]   paddr,
	input  logic [pcb_pkg::PDATA_W-1:0]   pwdata,
	output logic [pcb_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output pcb_pkg::cfg_t                 cfg
);
	import pcb_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_1D;
			cfg_q.inv_dx <= {3{INV_W'(65536)}};
			cfg_q.origin <= '0;
			cfg_q.len1   <= '0;
			cfg_q.len2   <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MODE:    cfg_q.mode      <= pwdata[1:0];
				REG_INV0:    cfg_q.inv_dx[0] <= pwdata;
				REG_INV1:    cfg_q.inv_dx[1] <= pwdata;
				REG_INV2:    cfg_q.inv_dx[2] <= pwdata;
				REG_ORG0:    cfg_q.origin[0] <= pwdata[ORG_W-1:0];
				REG_ORG1:    cfg_q.origin[1] <= pwdata[ORG_W-1:0];
				REG_ORG2:    cfg_q.origin[2] <= pwdata[ORG_W-1:0];
				REG_LENGTHS: begin
					cfg_q.len1 <= pwdata[LEN_W-1:0];
					cfg_q.len2 <= pwdata[2*LEN_W-1:LEN_W];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODE:    prdata = {30'd0, cfg_q.mode};
			REG_INV0:    prdata = cfg_q.inv_dx[0];
			REG_INV1:    prdata = cfg_q.inv_dx[1];
			REG_INV2:    prdata = cfg_q.inv_dx[2];
			REG_ORG0:    prdata = 32'(signed'(cfg_q.origin[0]));
			REG_ORG1:    prdata = 32'(signed'(cfg_q.origin[1]));
			REG_ORG2:    prdata = 32'(signed'(cfg_q.origin[2]));
			REG_LENGTHS: prdata = {8'd0, cfg_q.len2, cfg_q.len1};
			default:     prdata = '0;
		endcase
	end

endmodule

// ----- hdl/pcb_datapath.sv -----
// ----------------------------------------------------------------------------
// pcb_datapath
// scaling multiplier, key accumulator, square root unit, counter store
// and output register
// ----------------------------------------------------------------------------
module pcb_datapath #(
	parameter int NUM_CELLS  = pcb_pkg::NUM_CELLS_DEF,
	parameter int COUNT_BITS = pcb_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcb_pkg::cfg_t                 cfg,
	input  pcb_pkg::dp_cmd_t              cmd,
	output pcb_pkg::dp_sts_t              sts,
	input  logic [pcb_pkg::SDATA_W-1:0]   s_tdata,
	input  logic [pcb_pkg::SUSER_W-1:0]   s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pcb_pkg::MDATA_W-1:0]   m_tdata,
	output logic [pcb_pkg::MUSER_W-1:0]   m_tuser
);
	import pcb_pkg::*;

	localparam int AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	// item
	logic [1:0]       cmd_q;
	logic             excl_q;
	logic [IDX_W-1:0] idx_q;
	logic [2:0]       neg_q;
	logic [2:0][POS_W-1:0] mag_q;

	logic [PROD_W-1:0]       prod_q;
	logic [PROD_W-1:0]       sum_q;
	logic signed [KEY_W-1:0] acc_q;

	// square root
	logic [PROD_W-1:0] rad_q;
	logic [33:0]       rem_q;
	logic [31:0]       root_q;
	logic [4:0]        sq_cnt_q;

	// store
	logic [COUNT_BITS-1:0] mem [NUM_CELLS];
	logic [COUNT_BITS-1:0] rd_data_q;
	logic [AW-1:0]         clr_q;

	// pending result and output stage
	logic [IDX_W-1:0]      pk_q;
	logic                  pb_q, po_q;
	logic [COUNT_BITS-1:0] pc_q;
	logic                  m_valid_q;
	logic [IDX_W-1:0]      m_key_q;
	logic                  m_bin_q, m_oor_q;
	logic [OUTC_W-1:0]     m_cnt_q;

	logic [POS_W-1:0]        pos_in [3];
	logic [POS_W-1:0]        mul_a, mul_b;
	logic [31:0]             rnd;
	logic signed [KEY_W-1:0] c_mag, c_val, acc_d;
	logic [LEN_W-1:0]        len_sel;
	logic                    neg_sel;
	logic [35:0]             rem_sh, trial;
	logic                    key_oor, idx_oor;
	logic [AW-1:0]           key_addr, idx_addr, rd_addr;
	logic [COUNT_BITS-1:0]   inc_val;

	assign pos_in[0] = s_tdata[31:0];
	assign pos_in[1] = s_tdata[63:32];
	assign pos_in[2] = s_tdata[95:64];

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q  <= s_tuser[1:0];
			excl_q <= s_tuser[2];
			idx_q  <= s_tdata[107:96];
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= pos_in[i][POS_W-1];
				mag_q[i] <= pos_in[i][POS_W-1] ? (~pos_in[i] + 1'b1) : pos_in[i];
			end
		end
	end

	// shared 32x32 multiplier
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_X:   begin mul_a = mag_q[0]; mul_b = cfg.inv_dx[0]; end
			MUL_Y:   begin mul_a = mag_q[1]; mul_b = cfg.inv_dx[1]; end
			MUL_Z:   begin mul_a = mag_q[2]; mul_b = cfg.inv_dx[2]; end
			MUL_SQY: begin mul_a = mag_q[1]; mul_b = mag_q[1]; end
			MUL_SQZ: begin mul_a = mag_q[2]; mul_b = mag_q[2]; end
			MUL_RAD: begin mul_a = root_q;   mul_b = cfg.inv_dx[1]; end
			default: begin mul_a = '0;       mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (cmd.sum_load)
			sum_q <= prod_q;
	end

	// round half away from zero, subtract origin, fold into row-major key
	always_comb begin
		rnd     = 32'((prod_q + PROD_W'(64'h8000_0000)) >> 32);
		c_mag   = signed'(KEY_W'(rnd));
		neg_sel = cmd.radial ? 1'b0 : neg_q[cmd.axis];
		c_val   = (neg_sel ? -c_mag : c_mag) - KEY_W'(signed'(cfg.origin[cmd.axis]));
		len_sel = (cmd.fold_op == FOLD_L2) ? cfg.len2 : cfg.len1;
		acc_d   = acc_q * $signed({1'b0, len_sel}) + c_val;
	end

	always_ff @(posedge clk) begin
		unique case (cmd.fold_op)
			FOLD_LOAD:       acc_q <= c_val;
			FOLD_L1, FOLD_L2: acc_q <= acc_d;
			default: ;
		endcase
	end

	// restoring square root, one result bit per cycle
	assign rem_sh = {rem_q, rad_q[PROD_W-1:PROD_W-2]};
	assign trial  = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
		end else if (cmd.sqrt_init) begin
			sq_cnt_q <= '0;
		end else if (cmd.sqrt_step) begin
			sq_cnt_q <= sq_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			rad_q  <= sum_q + prod_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[PROD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= 34'(rem_sh - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	// counter store
	assign key_oor  = acc_q[KEY_W-1] || (acc_q >= KEY_W'(NUM_CELLS));
	assign idx_oor  = 32'(idx_q) >= 32'(NUM_CELLS);
	assign key_addr = acc_q[AW-1:0];
	assign idx_addr = AW'(32'(idx_q));
	assign rd_addr  = cmd.rd_key ? key_addr : idx_addr;
	assign inc_val  = (rd_data_q == CMAX) ? rd_data_q : rd_data_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.rd_key || cmd.rd_idx)
			rd_data_q <= mem[rd_addr];
		if (cmd.clr_step)
			mem[clr_q] <= '0;
		else if (cmd.inc_write)
			mem[key_addr] <= inc_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= sts.clr_done ? '0 : clr_q + 1'b1;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		unique case (cmd.flag_op)
			FL_ZERO: begin
				pk_q <= '0; pb_q <= 1'b0; po_q <= 1'b0; pc_q <= '0;
			end
			FL_READ: begin
				pk_q <= idx_q; pb_q <= 1'b0; po_q <= idx_oor;
				pc_q <= idx_oor ? '0 : rd_data_q;
			end
			FL_BIN_OOR: begin
				pk_q <= acc_q[IDX_W-1:0]; pb_q <= 1'b0; po_q <= 1'b1; pc_q <= '0;
			end
			FL_BIN_OK: begin
				pk_q <= acc_q[IDX_W-1:0]; pb_q <= 1'b1; po_q <= 1'b0; pc_q <= inc_val;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_key_q <= pk_q;
			m_bin_q <= pb_q;
			m_oor_q <= po_q;
			m_cnt_q <= OUTC_W'(32'(pc_q));
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, m_cnt_q, m_key_q};
	assign m_tuser  = {m_oor_q, m_bin_q};

	assign sts.cmd       = cmd_q;
	assign sts.excluded  = excl_q;
	assign sts.mode      = cfg.mode;
	assign sts.key_oor   = key_oor;
	assign sts.sqrt_done = (sq_cnt_q == 5'd31);
	assign sts.clr_done  = (32'(clr_q) == 32'(NUM_CELLS - 1));
	assign sts.out_free  = !m_valid_q || m_tready;

endmodule

// ----- hdl/pcb_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcb_ctrl
// sequencer that walks each command through the datapath
// ----------------------------------------------------------------------------
module pcb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  pcb_pkg::dp_sts_t  sts,
	output pcb_pkg::dp_cmd_t  cmd
);
	import pcb_pkg::*;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DISPATCH, S_CLR, S_RD_ISSUE, S_RD_LATCH,
		S_MUL_X, S_C0, S_MUL_Y, S_C1, S_MUL_Z, S_C2,
		S_SQ_Y, S_SQ_Z, S_SUM, S_SQRT, S_MUL_R, S_CR,
		S_KEY, S_MEM_INC, S_OUT
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			unique case (state_q)
				S_INIT:     if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE:     if (s_tvalid) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					priority if (sts.cmd == CMD_CLEAR) state_q <= S_CLR;
					else if (sts.cmd == CMD_READ) state_q <= S_RD_ISSUE;
					else if (sts.cmd == CMD_BIN && !sts.excluded) state_q <= S_MUL_X;
					else state_q <= S_OUT;
				end
				S_CLR:      if (sts.clr_done) state_q <= S_OUT;
				S_RD_ISSUE: state_q <= S_RD_LATCH;
				S_RD_LATCH: state_q <= S_OUT;
				S_MUL_X:    state_q <= S_C0;
				S_C0: begin
					unique case (sts.mode)
						MODE_1D:  state_q <= S_KEY;
						MODE_CYL: state_q <= S_SQ_Y;
						default:  state_q <= S_MUL_Y;
					endcase
				end
				S_MUL_Y:    state_q <= S_C1;
				S_C1:       state_q <= (sts.mode == MODE_3D) ? S_MUL_Z : S_KEY;
				S_MUL_Z:    state_q <= S_C2;
				S_C2:       state_q <= S_KEY;
				S_SQ_Y:     state_q <= S_SQ_Z;
				S_SQ_Z:     state_q <= S_SUM;
				S_SUM:      state_q <= S_SQRT;
				S_SQRT:     if (sts.sqrt_done) state_q <= S_MUL_R;
				S_MUL_R:    state_q <= S_CR;
				S_CR:       state_q <= S_KEY;
				S_KEY:      state_q <= sts.key_oor ? S_OUT : S_MEM_INC;
				S_MEM_INC:  state_q <= S_OUT;
				S_OUT:      if (sts.out_free) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = MUL_X;
		cmd.fold_op   = FOLD_NONE;
		cmd.axis      = AXIS_0;
		cmd.flag_op   = FL_NONE;
		cmd.load_item = s_tready & s_tvalid;
		unique case (state_q)
			S_INIT:     cmd.clr_step = 1'b1;
			S_DISPATCH: cmd.flag_op = FL_ZERO;
			S_CLR:      cmd.clr_step = 1'b1;
			S_RD_ISSUE: cmd.rd_idx = 1'b1;
			S_RD_LATCH: cmd.flag_op = FL_READ;
			S_MUL_X:    begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_X; end
			S_C0:       begin cmd.fold_op = FOLD_LOAD; cmd.axis = AXIS_0; end
			S_MUL_Y:    begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_Y; end
			S_C1:       begin cmd.fold_op = FOLD_L1; cmd.axis = AXIS_1; end
			S_MUL_Z:    begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_Z; end
			S_C2:       begin cmd.fold_op = FOLD_L2; cmd.axis = AXIS_2; end
			S_SQ_Y:     begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_SQY; end
			S_SQ_Z: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_SQZ;
				cmd.sum_load = 1'b1;
			end
			S_SUM:      cmd.sqrt_init = 1'b1;
			S_SQRT:     cmd.sqrt_step = 1'b1;
			S_MUL_R:    begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_RAD; end
			S_CR: begin
				cmd.fold_op = FOLD_L1;
				cmd.axis    = AXIS_1;
				cmd.radial  = 1'b1;
			end
			S_KEY: begin
				if (sts.key_oor)
					cmd.flag_op = FL_BIN_OOR;
				else
					cmd.rd_key = 1'b1;
			end
			S_MEM_INC: begin
				cmd.inc_write = 1'b1;
				cmd.flag_op   = FL_BIN_OK;
			end
			S_OUT:      cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ----- tb/particle_cell_binning_unit_tb.sv -----
// ----------------------------------------------------------------------------
// particle_cell_binning_unit_tb
// self-checking bench for the particle cell binning unit: items go in over
// the slave stream, a local histogram model predicts each result and the
// master stream is compared field by field; registers are set over apb
// ----------------------------------------------------------------------------
module particle_cell_binning_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pcb_pkg::*;

	localparam int CELLS = NUM_CELLS_DEF;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [11:0] key;
		logic        binned;
		logic        oor;
		logic [15:0] count;
	} bin_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SDATA_W-1:0] s_tdata = '0;
	logic [SUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [MDATA_W-1:0] m_tdata;
	logic [MUSER_W-1:0] m_tuser;

	// shadow registers and histogram
	logic [1:0]         sh_mode;
	logic [31:0]        sh_inv [3];
	logic signed [15:0] sh_org [3];
	logic [23:0]        sh_len;
	logic [15:0]        tally [CELLS];

	bin_result_t expected_bins[$];
	int errors = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int hold_request = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	particle_cell_binning_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
		errors++;
		$display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
	endtask

	function automatic longint scaled_cell(logic signed [31:0] p, logic [31:0] inv);
		longint unsigned mag;
		longint unsigned r;
		mag = (p < 0) ? longint'(-longint'(p)) : longint'(p);
		r = (mag * longint'({32'b0, inv}) + 64'h8000_0000) >> 32;
		return (p < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned res;
		longint unsigned probe;
		res = 0;
		probe = 64'h1 << 62;
		while (probe > v)
			probe >>= 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v -= res + probe;
				res = (res >> 1) + probe;
			end else begin
				res >>= 1;
			end
			probe >>= 2;
		end
		return res;
	endfunction

	// advances the histogram and returns what the block should answer
	function automatic bin_result_t bin_predict(logic [1:0] cmd, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic excl, logic [11:0] idx);
		bin_result_t res;
		longint c0, c1, c2, key, l1, l2;
		longint unsigned ay, az, rad, cr;
		res = '0;
		l1 = sh_len[11:0];
		l2 = sh_len[23:12];
		case (cmd)
			CMD_CLEAR: begin
				foreach (tally[i]) tally[i] = '0;
			end
			CMD_BIN: begin
				if (!excl) begin
					c0 = scaled_cell(x, sh_inv[0]) - sh_org[0];
					case (sh_mode)
						MODE_1D: key = c0;
						MODE_2D: begin
							c1 = scaled_cell(y, sh_inv[1]) - sh_org[1];
							key = c0 * l1 + c1;
						end
						MODE_3D: begin
							c1 = scaled_cell(y, sh_inv[1]) - sh_org[1];
							c2 = scaled_cell(z, sh_inv[2]) - sh_org[2];
							key = (c0 * l1 + c1) * l2 + c2;
						end
						default: begin
							ay = (y < 0) ? -longint'(y) : longint'(y);
							az = (z < 0) ? -longint'(z) : longint'(z);
							rad = int_root(ay * ay + az * az);
							cr = (rad * longint'({32'b0, sh_inv[1]}) + 64'h8000_0000) >> 32;
							key = c0 * l1 + (longint'(cr) - sh_org[1]);
						end
					endcase
					res.key = key[11:0];
					if (key < 0 || key >= CELLS) begin
						res.oor = 1'b1;
					end else begin
						if (tally[key] != 16'hFFFF)
							tally[key]++;
						res.binned = 1'b1;
						res.count = tally[key];
					end
				end
			end
			CMD_READ: begin
				res.key = idx;
				res.count = tally[idx];
			end
			default: ;
		endcase
		return res;
	endfunction

	// ---------------- result side ----------------
	int stall_left = 0;
	always @(posedge clk) begin
		bin_result_t want;
		int r;
		if (m_tvalid && m_tready) begin
			if (expected_bins.size() == 0) begin
				report_mismatch("unexpected item", 0, {m_tuser, m_tdata});
			end else begin
				want = expected_bins.pop_front();
				if (m_tdata[11:0] !== want.key)
					report_mismatch("cell_key", want.key, m_tdata[11:0]);
				if (m_tdata[27:12] !== want.count)
					report_mismatch("bin_count", want.count, m_tdata[27:12]);
				if (m_tuser[0] !== want.binned)
					report_mismatch("binned", want.binned, m_tuser[0]);
				if (m_tuser[1] !== want.oor)
					report_mismatch("out_of_range", want.oor, m_tuser[1]);
			end
		end
		if (hold_request > 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!stalls_on || !arst_n) begin
			m_tready <= arst_n;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(15, 60);
			end
		end
	end

	// ---------------- stimulus side ----------------
	task automatic send_item(logic [1:0] cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic excl, logic [11:0] idx);
		int gap;
		int r;
		gap = 0;
		if (gaps_on) begin
			r = $urandom_range(0, 99);
			if (r >= 55)
				gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, idx, z, y, x};
		s_tuser <= {excl, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_bins = {expected_bins, bin_predict(cmd, x, y, z, excl, idx)};
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_bins.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE:    sh_mode = val[1:0];
			REG_INV0:    sh_inv[0] = val;
			REG_INV1:    sh_inv[1] = val;
			REG_INV2:    sh_inv[2] = val;
			REG_ORG0:    sh_org[0] = val[15:0];
			REG_ORG1:    sh_org[1] = val[15:0];
			REG_ORG2:    sh_org[2] = val[15:0];
			default:     sh_len = val[23:0];
		endcase
	endtask

	task automatic set_geometry(logic [1:0] mode, logic [31:0] i0, logic [31:0] i1,
			logic [31:0] i2, logic [15:0] o0, logic [15:0] o1, logic [15:0] o2,
			logic [23:0] len);
		reg_write(REG_MODE, {30'b0, mode});
		reg_write(REG_INV0, i0);
		reg_write(REG_INV1, i1);
		reg_write(REG_INV2, i2);
		reg_write(REG_ORG0, {16'b0, o0});
		reg_write(REG_ORG1, {16'b0, o1});
		reg_write(REG_ORG2, {16'b0, o2});
		reg_write(REG_LENGTHS, {8'b0, len});
	endtask

	task automatic bin_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		send_item(CMD_BIN, x, y, z, 1'b0, 12'd0);
	endtask

	task automatic test_directed;
		// 1d at reset values: rounding, halves, both ends of the position range
		bin_at(32'h0003_0000, 0, 0);
		bin_at(32'h0003_0000, 0, 0);
		bin_at(32'h0002_8000, 0, 0);
		bin_at(32'hFFFD_8000, 0, 0);
		bin_at(32'h7FFF_FFFF, 0, 0);
		bin_at(32'h8000_0000, 0, 0);
		bin_at(32'h0000_7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_BIN, 32'h0003_0000, 0, 0, 1'b1, 12'hFFF);
		send_item(CMD_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 12'hFFF);
		send_item(CMD_READ, 0, 0, 0, 1'b0, 12'd3);
		send_item(CMD_READ, 0, 0, 0, 1'b0, 12'hFFF);
		send_item(CMD_CLEAR, 0, 0, 0, 1'b0, 12'd0);
		send_item(CMD_READ, 0, 0, 0, 1'b0, 12'd3);
		drain();
		// 3d, small grid
		set_geometry(MODE_3D, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000,
			16'hFFFF, 16'd1, 16'd0, {12'd5, 12'd7});
		bin_at(32'h0002_0000, 32'h0001_8000, 32'h0003_0000);
		bin_at(32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000);
		bin_at(32'h0000_0000, 32'hFFFF_0000, 32'h0009_0000);
		drain();
		// cylindrical: 3-4-5 triangle, then extreme radius
		set_geometry(MODE_CYL, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF,
			16'd0, 16'd0, 16'h8000, {12'd0, 12'd10});
		bin_at(32'h0001_0000, 32'h0003_0000, 32'hFFFC_0000);
		bin_at(32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
		bin_at(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
		drain();
		// register extremes
		set_geometry(MODE_2D, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
			16'h8000, 16'h7FFF, 16'h7FFF, 24'hFF_FFFF);
		bin_at(32'h8000_0000, 32'h7FFF_FFFF, 0);
		bin_at(32'h0000_0000, 32'h0000_0000, 0);
		drain();
	endtask

	// one cell hit back to back, then read and cleared
	task automatic test_hot_cell;
		set_geometry(MODE_1D, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			16'd0, 16'd0, 16'd0, 24'd0);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		repeat (40) bin_at(32'h0005_0000, 0, 0);
		send_item(CMD_READ, 0, 0, 0, 1'b0, 12'd5);
		send_item(CMD_CLEAR, 0, 0, 0, 1'b0, 12'd0);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		drain();
	endtask

	task automatic random_item;
		int r;
		logic [31:0] x, y, z;
		r = $urandom_range(0, 99);
		x = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		y = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		z = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		if (r < 15) begin
			x = $urandom;
			y = $urandom;
			z = $urandom;
		end
		if (r < 70)
			send_item(CMD_BIN, x, y, z, ($urandom_range(0, 9) == 0), 12'($urandom));
		else if (r < 88)
			send_item(CMD_READ, $urandom, $urandom, $urandom, 1'($urandom), 12'($urandom));
		else if (r < 91)
			send_item(CMD_CLEAR, $urandom, $urandom, $urandom, 1'($urandom), 12'($urandom));
		else
			send_item(CMD_SPARE, $urandom, $urandom, $urandom, 1'($urandom), 12'($urandom));
	endtask

	task automatic test_random;
		logic [31:0] inv [3];
		for (int ph = 0; ph < 7; ph++) begin
			for (int a = 0; a < 3; a++)
				inv[a] = ($urandom_range(0, 4) == 0) ? $urandom :
					$urandom_range(32'h0000_8000, 32'h0002_0000);
			if (ph == 6)
				set_geometry(MODE_CYL, $urandom, $urandom, $urandom,
					16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
			else
				set_geometry(2'($urandom_range(0, 3)), inv[0], inv[1], inv[2],
					16'($urandom_range(0, 8) - 4), 16'($urandom_range(0, 8) - 4),
					16'($urandom_range(0, 8) - 4),
					{12'($urandom_range(1, 12)), 12'($urandom_range(1, 20))});
			repeat (90) random_item();
			drain();
		end
	endtask

	task automatic test_backpressure;
		set_geometry(MODE_2D, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			16'd0, 16'd0, 16'd0, {12'd4, 12'd8});
		gaps_on = 1'b0;
		@(posedge clk);
		hold_request = 400;
		repeat (20) random_item();
		gaps_on = 1'b1;
		drain();
		repeat (10) random_item();
		drain();
	endtask

	initial begin
		sh_mode = MODE_1D;
		foreach (sh_inv[a]) sh_inv[a] = 32'h0001_0000;
		foreach (sh_org[a]) sh_org[a] = '0;
		sh_len = '0;
		foreach (tally[i]) tally[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_hot_cell();
		test_random();
		test_backpressure();
		if (errors == 0)
			$display("** particle_cell_binning_unit: PASSED **");
		else
			$display("** particle_cell_binning_unit: FAILED **");
		$finish;
	end

	initial begin
		#40ms;
		$display("** particle_cell_binning_unit: FAILED **");
		$finish;
	end

endmodule
